@@ rtl/qra_pkg.sv @@
// Package with shared types and constants for the quota resource allocator.
`timescale 1ns / 1ps
package qra_pkg;
  localparam int CLIENTS = 32;
  localparam int SLOT_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CNT_W = $clog2(CLIENTS + 1);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE = 2'd1;
  localparam logic [1:0] REQ_SETQ = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  localparam logic [1:0] KIND_MEM = 2'd0;
  localparam logic [1:0] KIND_FD = 2'd1;
  localparam logic [1:0] KIND_PORT = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUDGET = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic [2:0] CFG_DEF_FD = 3'd0;
  localparam logic [2:0] CFG_DEF_PORT = 3'd1;
  localparam logic [2:0] CFG_DEF_MEM = 3'd2;
  localparam logic [2:0] CFG_POOL = 3'd3;
  localparam logic [2:0] CFG_FD_LIM = 3'd4;
  localparam logic [2:0] CFG_PORT_LIM = 3'd5;

  // One slot search request and its answer.
  typedef struct packed {
    logic start;
    logic [31:0] id;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic found;
    logic [SLOT_W-1:0] hit;
    logic has_free;
    logic [SLOT_W-1:0] free_slot;
  } srch_rsp_t;
endpackage

@@ rtl/qra_search.sv @@
// Sequential slot search: one id compare per cycle over all slots.
`timescale 1ns / 1ps
module qra_search (
  input  logic clk,
  input  logic rst,
  input  qra_pkg::srch_req_t req,
  input  logic [qra_pkg::CLIENTS-1:0] valid_bits,
  output logic [qra_pkg::SLOT_W-1:0] rd_addr,
  input  logic [31:0] rd_id,
  output qra_pkg::srch_rsp_t rsp
);
  logic busy;
  logic done;
  logic [qra_pkg::CNT_W-1:0] idx;
  logic [qra_pkg::SLOT_W-1:0] cur;
  logic cur_live;
  logic found, has_free;
  logic [qra_pkg::SLOT_W-1:0] hit, free_slot;
  logic [31:0] id;

  // The id memory read address; data of slot cur arrives in the cycle after.
  assign rd_addr = idx[qra_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cur_live <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        idx <= '0;
        cur_live <= 1'b0;
        found <= 1'b0;
        has_free <= 1'b0;
        id <= req.id;
      end else if (busy) begin
        // Compare the slot read last cycle, keep lowest match and free slot.
        if (cur_live) begin
          if (valid_bits[cur] && rd_id == id && !found) begin
            found <= 1'b1;
            hit <= cur;
          end
          if (!valid_bits[cur] && !has_free) begin
            has_free <= 1'b1;
            free_slot <= cur;
          end
        end
        if (idx == qra_pkg::CNT_W'(qra_pkg::CLIENTS)) begin
          busy <= 1'b0;
          cur_live <= 1'b0;
          done <= 1'b1;
        end else begin
          cur <= idx[qra_pkg::SLOT_W-1:0];
          cur_live <= 1'b1;
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // Final answers include the last compare, whose result is registered together with done.
  always_comb begin
    rsp.done = done;
    rsp.found = found;
    rsp.hit = hit;
    rsp.has_free = has_free;
    rsp.free_slot = free_slot;
  end
endmodule

@@ rtl/quota_resource_allocator.sv @@
// Top level of the per-client quota allocator: sequencer, slot tables, totals.
//  channel | direction | signals
//  in      | input     | in_valid, in_ready, req_type .. new_mem_limit
//  out     | output    | out_valid, out_ready, status .. global_available
//  cfg     | input     | cfg_we, cfg_index, cfg_data
// The result of an allocate or set quota shows after the slot search, which compares
// one stored id per cycle through the id memory read port. A valid free adds a step
// for its total, a release of a held slot a step per total for the three totals.
// The next item can be accepted once the result has been taken, so items do not overlap.
// Reset clears slot valid bits and the usage totals and loads the default configuration.
// in_ready is low from acceptance until the result is taken by out_ready.
`timescale 1ns / 1ps
module quota_resource_allocator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] req_type,
  input  logic [31:0] client_id,
  input  logic [1:0] res_kind,
  input  logic [31:0] amount,
  input  logic [31:0] new_fd_limit,
  input  logic [31:0] new_port_limit,
  input  logic [31:0] new_mem_limit,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [31:0] grant_value,
  output logic [31:0] used_after,
  output logic [31:0] global_available,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_READ = 4'd2;
  localparam logic [3:0] S_CHK = 4'd3;
  localparam logic [3:0] S_CHK_TOT = 4'd4;
  localparam logic [3:0] S_REL = 4'd5;
  localparam logic [3:0] S_AVL = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;
  localparam logic [3:0] S_WAIT = 4'd8;

  logic [3:0] state;
  logic [31:0] def_fd, def_port, def_mem, pool_sz, fd_lim, port_lim;
  logic [31:0] tot_mem, tot_fd, tot_port;
  logic [qra_pkg::CLIENTS-1:0] vbits;

  // Slot memories, read with registered data.
  logic [31:0] id_mem [qra_pkg::CLIENTS];
  logic [95:0] bud_mem [qra_pkg::CLIENTS];
  logic [95:0] use_mem [qra_pkg::CLIENTS];
  logic [31:0] id_rd;
  logic [95:0] bud_rd, use_rd;
  logic [qra_pkg::SLOT_W-1:0] srch_addr, slot;

  // Latched item.
  logic [1:0] rq, kd;
  logic [31:0] cid, amt, nfd, nport, nmem;
  logic slot_ok, claimed;

  qra_pkg::srch_req_t sreq;
  qra_pkg::srch_rsp_t srsp;

  // Shared 33-bit adder/subtractor operands and result.
  logic [31:0] op_a, op_b;
  logic op_sub;
  logic [32:0] alu;
  logic [31:0] alu_sat;

  logic [31:0] bud_k, use_k, tot_k, lim_k;
  logic [31:0] use_new, grant_r;
  logic [1:0] st_r;
  logic vk;

  logic [95:0] bud_next_w, use_next_w;
  logic [95:0] bud_base, use_base;

  logic [31:0] rel_sub;
  logic [1:0] rel_step;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_WAIT);
  assign sreq.start = in_valid && in_ready;
  assign sreq.id = client_id;
  assign vk = (kd != qra_pkg::KIND_BAD);

  qra_search u_search (
    .clk(clk), .rst(rst), .req(sreq), .valid_bits(vbits),
    .rd_addr(srch_addr), .rd_id(id_rd), .rsp(srsp)
  );

  // Per-kind selections of the read slot and the totals.
  always_comb begin
    unique case (kd)
      qra_pkg::KIND_MEM: begin
        bud_k = bud_rd[31:0]; use_k = use_rd[31:0]; tot_k = tot_mem; lim_k = pool_sz;
      end
      qra_pkg::KIND_FD: begin
        bud_k = bud_rd[63:32]; use_k = use_rd[63:32]; tot_k = tot_fd; lim_k = fd_lim;
      end
      default: begin
        bud_k = bud_rd[95:64]; use_k = use_rd[95:64]; tot_k = tot_port;
        lim_k = port_lim;
      end
    endcase
    if (claimed) begin
      unique case (kd)
        qra_pkg::KIND_MEM: bud_k = def_mem;
        qra_pkg::KIND_FD: bud_k = def_fd;
        default: bud_k = def_port;
      endcase
      use_k = '0;
    end
  end

  assign alu = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
  assign alu_sat = alu[32] ? 32'd0 : alu[31:0];

  // Memory read port and writes.
  always_ff @(posedge clk) begin
    id_rd <= id_mem[(state == S_SRCH) ? srch_addr : slot];
    bud_rd <= bud_mem[slot];
    use_rd <= use_mem[slot];
    if (state == S_SRCH && srsp.done && !srsp.found && srsp.has_free &&
        (rq == qra_pkg::REQ_ALLOC || rq == qra_pkg::REQ_SETQ))
      id_mem[srsp.free_slot] <= cid;
    if (state == S_OUT && slot_ok) begin
      bud_mem[slot] <= bud_next_w;
      use_mem[slot] <= use_next_w;
    end
  end

  // New budgets and usage of the addressed slot.
  always_comb begin
    bud_base = claimed ? {def_port, def_fd, def_mem} : bud_rd;
    use_base = (claimed || rq == qra_pkg::REQ_RELEASE) ? 96'd0 : use_rd;
    bud_next_w = bud_base;
    use_next_w = use_base;
    if (rq == qra_pkg::REQ_SETQ) begin
      if (nmem != '0) bud_next_w[31:0] = nmem;
      if (nfd != '0) bud_next_w[63:32] = nfd;
      if (nport != '0) bud_next_w[95:64] = nport;
    end else if (rq != qra_pkg::REQ_RELEASE && vk) begin
      unique case (kd)
        qra_pkg::KIND_MEM: use_next_w[31:0] = use_new;
        qra_pkg::KIND_FD: use_next_w[63:32] = use_new;
        default: use_next_w[95:64] = use_new;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vbits <= '0;
      tot_mem <= '0;
      tot_fd <= '0;
      tot_port <= '0;
      def_fd <= 32'd256;
      def_port <= 32'd64;
      def_mem <= 32'd33554432;
      pool_sz <= 32'd268435456;
      fd_lim <= 32'd4096;
      port_lim <= 32'd65535;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          qra_pkg::CFG_DEF_FD: def_fd <= cfg_data;
          qra_pkg::CFG_DEF_PORT: def_port <= cfg_data;
          qra_pkg::CFG_DEF_MEM: def_mem <= cfg_data;
          qra_pkg::CFG_POOL: pool_sz <= cfg_data;
          qra_pkg::CFG_FD_LIM: fd_lim <= cfg_data;
          qra_pkg::CFG_PORT_LIM: port_lim <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rq <= req_type; kd <= res_kind; cid <= client_id; amt <= amount;
            nfd <= new_fd_limit; nport <= new_port_limit; nmem <= new_mem_limit;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (srsp.done) begin
            claimed <= 1'b0;
            slot_ok <= 1'b0;
            if (srsp.found) begin
              slot <= srsp.hit; slot_ok <= 1'b1;
            end else if ((rq == qra_pkg::REQ_ALLOC || rq == qra_pkg::REQ_SETQ) &&
                         srsp.has_free) begin
              slot <= srsp.free_slot; slot_ok <= 1'b1; claimed <= 1'b1;
              vbits[srsp.free_slot] <= 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          // Memory data for slot is registered now, ready in S_CHK; first op: usage +/- amount.
          state <= S_CHK;
          rel_step <= 2'd0;
        end
        S_CHK: begin
          st_r <= qra_pkg::ST_OK;
          grant_r <= '0;
          use_new <= use_k;
          state <= S_AVL;
          unique case (rq)
            qra_pkg::REQ_ALLOC: begin
              if (!slot_ok) st_r <= qra_pkg::ST_FULL;
              else if (!vk) st_r <= qra_pkg::ST_INVALID;
              else if (alu > {1'b0, bud_k}) st_r <= qra_pkg::ST_BUDGET;
              else if (({1'b0, tot_k} + {1'b0, amt}) > {1'b0, lim_k})
                st_r <= qra_pkg::ST_FULL;
              else begin
                use_new <= alu[31:0];
                grant_r <= (kd == qra_pkg::KIND_MEM) ? tot_k : alu[31:0];
                unique case (kd)
                  qra_pkg::KIND_MEM: tot_mem <= tot_mem + amt;
                  qra_pkg::KIND_FD: tot_fd <= tot_fd + amt;
                  default: tot_port <= tot_port + amt;
                endcase
              end
            end
            qra_pkg::REQ_FREE: begin
              if (!slot_ok || !vk) st_r <= qra_pkg::ST_INVALID;
              else begin
                use_new <= (use_k < amt) ? 32'd0 : alu[31:0];
                rel_sub <= (use_k < amt) ? use_k : amt;
                rel_step <= 2'd1;
                state <= S_CHK_TOT;
              end
            end
            qra_pkg::REQ_SETQ: begin
              if (!slot_ok) st_r <= qra_pkg::ST_FULL;
            end
            default: begin
              if (slot_ok) begin
                vbits[slot] <= 1'b0;
                state <= S_REL;
              end
            end
          endcase
        end
        S_CHK_TOT: begin
          // Free of descriptor or port lowers its total, saturating.
          if (kd == qra_pkg::KIND_FD) tot_fd <= alu_sat;
          else if (kd == qra_pkg::KIND_PORT) tot_port <= alu_sat;
          state <= S_AVL;
        end
        S_REL: begin
          // Release: one total per cycle through the shared subtractor.
          unique case (rel_step)
            2'd0: tot_fd <= alu_sat;
            2'd1: tot_port <= alu_sat;
            default: tot_mem <= alu_sat;
          endcase
          rel_step <= rel_step + 1'b1;
          if (rel_step == 2'd2) state <= S_AVL;
        end
        S_AVL: begin
          status <= st_r;
          grant_value <= grant_r;
          used_after <= (vk && slot_ok && rq != qra_pkg::REQ_RELEASE) ? use_new : 32'd0;
          global_available <= vk ? alu_sat : 32'd0;
          state <= S_OUT;
        end
        S_OUT: state <= S_WAIT;
        default: begin
          if (out_ready) state <= S_IDLE;
        end
      endcase
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    op_a = use_k; op_b = amt; op_sub = 1'b0;
    unique case (state)
      S_CHK: begin
        op_a = use_k; op_b = amt; op_sub = (rq == qra_pkg::REQ_FREE);
      end
      S_CHK_TOT: begin
        op_a = tot_k; op_b = rel_sub; op_sub = 1'b1;
      end
      S_REL: begin
        op_sub = 1'b1;
        unique case (rel_step)
          2'd0: begin op_a = tot_fd; op_b = use_rd[63:32]; end
          2'd1: begin op_a = tot_port; op_b = use_rd[95:64]; end
          default: begin op_a = tot_mem; op_b = use_rd[31:0]; end
        endcase
      end
      S_AVL: begin op_a = lim_k; op_b = tot_k; op_sub = 1'b1; end
      default: ;
    endcase
  end
endmodule

@@ rtl/qra_checker.sv @@
// Port-level checker for the quota allocator, bound to the top level.
`timescale 1ns / 1ps
module qra_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic [31:0] grant_value,
  input logic [31:0] global_available
);
  // No new item is taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  // An accepted item leaves the block busy the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  // Only a granted item carries a grant value.
  a_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != qra_pkg::ST_OK) |-> grant_value == 32'd0)
    else $error("grant on failed request");
  // A held result keeps its global_available value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(global_available))
    else $error("result changed while stalled");
endmodule

bind quota_resource_allocator qra_checker u_qra_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .grant_value(grant_value), .global_available(global_available)
);
